// ===== sv/ukhc_pkg.sv =====
// Shared types, constants and helpers for the unique key hit counter.
`default_nettype none
package ukhc_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int HIT_WIDTH   = 32;
    localparam int KEY_W       = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_HITS_W  = 32;
    localparam int OUT_CNT_W   = 7;

    // Request opcodes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_DUMP  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_REJECTED = 3'd0;
    localparam logic [2:0] ST_HIT      = 3'd1;
    localparam logic [2:0] ST_APPENDED = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_DUMP     = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    localparam logic [KEY_W-1:0]     NO_KEY  = '1;
    localparam logic [HIT_WIDTH-1:0] HIT_MAX = '1;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [2:0]            status;
        logic [KEY_W-1:0]      entry_key;
        logic [OUT_HITS_W-1:0] entry_hits;
        logic [OUT_CNT_W-1:0]  entry_count;
        logic                  last;
    } res_t;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [HIT_WIDTH-1:0] hits;
    } entry_t;

    typedef enum logic [0:0] {
        RD_IDX    = 1'b0,
        RD_POS_M1 = 1'b1
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_APPEND = 2'd0,
        WR_HIT    = 2'd1,
        WR_SHIFT  = 2'd2,
        WR_HOLD   = 2'd3
    } wr_sel_t;

    typedef enum logic [2:0] {
        RES_REJECT = 3'd0,
        RES_HIT    = 3'd1,
        RES_APPEND = 3'd2,
        RES_FULL   = 3'd3,
        RES_DUMP   = 3'd4,
        RES_EMPTY  = 3'd5
    } res_sel_t;

    typedef struct packed {
        logic     load_req;
        logic     clr_used;
        logic     inc_used;
        logic     idx_clr;
        logic     idx_one;
        logic     idx_inc;
        logic     pos_load;
        logic     pos_dec;
        logic     hold_load;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     out_load;
        res_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       key_ones;
        logic       full;
        logic       used_zero;
        logic       idx_at_used;
        logic       idx_last;
        logic       match;
        logic       pos_zero;
        logic       hits_lt;
        logic       out_free;
    } stat_t;

    // Low 32 bits of a hit count, zero-extended when narrower
    function automatic logic [OUT_HITS_W-1:0] hits_out(input logic [HIT_WIDTH-1:0] h);
        logic [HIT_WIDTH+OUT_HITS_W-1:0] ext;
        ext = {{OUT_HITS_W{1'b0}}, h};
        return ext[OUT_HITS_W-1:0];
    endfunction

    function automatic logic [OUT_CNT_W-1:0] cnt_out(input logic [CNT_W-1:0] c);
        logic [CNT_W+OUT_CNT_W-1:0] ext;
        ext = {{OUT_CNT_W{1'b0}}, c};
        return ext[OUT_CNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/unique_key_hit_counter.sv =====
// Top level of the unique key hit counter: controller plus datapath.
//
// Requests arrive on req (op, key) with req_valid/req_ready; results leave
// on res (status, entry_key, entry_hits, entry_count, last) with
// res_valid/res_ready. One request is worked at a time; req_ready is high
// only while the controller is idle, but a finished result may still sit
// in the output register while the next request is taken.
// A rejected key, clear, unused op or empty dump loads its result from the
// decode state once the output register is free, then returns to idle. An
// add walks the table through its one RAM read port, with a read and a
// compare state per stored entry: a hit answers from the compare state, an
// append or a drop once the scan reaches the entry count (up to 64). A dump
// runs an insertion sort through the same port and then emits the entries
// one by one in order, the final one with last set.
// Reset clears the entry count and the controller; table contents are not
// cleared and are only read below the entry count.
// When the receiver stalls, the block holds the pending result and waits
// before loading the next one; nothing is dropped.
`default_nettype none
module unique_key_hit_counter (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire ukhc_pkg::req_t req,
    output logic                res_valid,
    input  wire logic           res_ready,
    output ukhc_pkg::res_t      res
);
    import ukhc_pkg::*;

    cmd_t  cmd;
    stat_t st;

    ukhc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .st        (st),
        .cmd       (cmd)
    );

    ukhc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .st        (st),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule
`default_nettype wire

// ===== sv/ukhc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module ukhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/ukhc_ctrl.sv =====
// Controller state machine: lookup, insertion sort, dump and clear sequencing.
`default_nettype none
module ukhc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire ukhc_pkg::stat_t st,
    output ukhc_pkg::cmd_t     cmd
);
    import ukhc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DECODE   = 10'b00_0000_0010,
        S_SCAN     = 10'b00_0000_0100,
        S_SCAN_CMP = 10'b00_0000_1000,
        S_SORT_I   = 10'b00_0001_0000,
        S_SORT_LD  = 10'b00_0010_0000,
        S_SORT_CHK = 10'b00_0100_0000,
        S_SORT_CMP = 10'b00_1000_0000,
        S_DUMP_RD  = 10'b01_0000_0000,
        S_DUMP_OUT = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel  = RD_IDX;
        cmd.wr_sel  = WR_APPEND;
        cmd.out_sel = RES_REJECT;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (st.op)
                    OP_ADD:
                    begin
                        if (st.key_ones)
                        begin
                            if (st.out_free)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = RES_REJECT;
                                state_next   = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_SCAN;
                        end
                    end
                    OP_DUMP:
                    begin
                        if (st.used_zero)
                        begin
                            if (st.out_free)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = RES_EMPTY;
                                state_next   = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.idx_one = 1'b1;
                            state_next  = S_SORT_I;
                        end
                    end
                    OP_CLEAR:
                    begin
                        if (st.out_free)
                        begin
                            cmd.clr_used = 1'b1;
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = RES_EMPTY;
                            state_next   = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (st.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = RES_REJECT;
                            state_next   = S_IDLE;
                        end
                    end
                endcase
            end
            // Walk the table for a matching key
            S_SCAN:
            begin
                if (!st.idx_at_used)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    state_next = S_SCAN_CMP;
                end
                else if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (st.full)
                    begin
                        cmd.out_sel = RES_FULL;
                    end
                    else
                    begin
                        cmd.out_sel  = RES_APPEND;
                        cmd.wr_en    = 1'b1;
                        cmd.wr_sel   = WR_APPEND;
                        cmd.inc_used = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_SCAN_CMP:
            begin
                if (st.match)
                begin
                    if (st.out_free)
                    begin
                        cmd.wr_en    = 1'b1;
                        cmd.wr_sel   = WR_HIT;
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = RES_HIT;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            // Insertion sort, descending by hits, stable
            S_SORT_I:
            begin
                if (st.idx_at_used)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_DUMP_RD;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = RD_IDX;
                    cmd.pos_load = 1'b1;
                    state_next   = S_SORT_LD;
                end
            end
            S_SORT_LD:
            begin
                cmd.hold_load = 1'b1;
                state_next    = S_SORT_CHK;
            end
            S_SORT_CHK:
            begin
                if (st.pos_zero)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = WR_HOLD;
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SORT_I;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_POS_M1;
                    state_next = S_SORT_CMP;
                end
            end
            S_SORT_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (st.hits_lt)
                begin
                    cmd.wr_sel  = WR_SHIFT;
                    cmd.pos_dec = 1'b1;
                    state_next  = S_SORT_CHK;
                end
                else
                begin
                    cmd.wr_sel  = WR_HOLD;
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SORT_I;
                end
            end
            // Emit every entry in order
            S_DUMP_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX;
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = RES_DUMP;
                    cmd.idx_inc  = 1'b1;
                    state_next   = S_DUMP_RD;
                    if (st.idx_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/ukhc_dp.sv =====
// Datapath: table RAM, counters, compare logic and the result register.
`default_nettype none
module ukhc_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ukhc_pkg::req_t req,
    input  wire ukhc_pkg::cmd_t cmd,
    output ukhc_pkg::stat_t     st,
    output logic                res_valid,
    input  wire logic           res_ready,
    output ukhc_pkg::res_t      res
);
    import ukhc_pkg::*;

    logic [1:0]           op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    entry_t               hold_reg;
    res_t                 res_reg, res_next;
    logic                 res_valid_reg, res_valid_next;

    entry_t               rd_data;
    entry_t               wr_data;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     rd_addr;
    logic [HIT_WIDTH-1:0] hits_inc;
    logic [CNT_W-1:0]     idx_plus1;
    logic                 idx_last;

    ukhc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Capture the request and the held sort entry
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg  <= req.op;
            key_reg <= req.key;
        end
        if (cmd.hold_load)
        begin
            hold_reg <= rd_data;
        end
    end

    // Counters
    always_comb
    begin
        used_next = used_reg;
        if (cmd.clr_used)
        begin
            used_next = '0;
        end
        else if (cmd.inc_used)
        begin
            used_next = used_reg + 1'b1;
        end

        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_one)
        begin
            idx_next = CNT_W'(1);
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_plus1;
        end

        pos_next = pos_reg;
        if (cmd.pos_load)
        begin
            pos_next = idx_reg[IDX_W-1:0];
        end
        else if (cmd.pos_dec)
        begin
            pos_next = pos_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign idx_plus1 = idx_reg + 1'b1;
    assign idx_last  = (idx_plus1 == used_reg);
    assign hits_inc  = (rd_data.hits == HIT_MAX) ? rd_data.hits : rd_data.hits + 1'b1;

    // RAM addresses and write data
    always_comb
    begin
        rd_addr = (cmd.rd_sel == RD_POS_M1) ? pos_reg - 1'b1 : idx_reg[IDX_W-1:0];
        case (cmd.wr_sel)
            WR_APPEND:
            begin
                wr_addr      = used_reg[IDX_W-1:0];
                wr_data.key  = key_reg;
                wr_data.hits = HIT_WIDTH'(1);
            end
            WR_HIT:
            begin
                wr_addr      = idx_reg[IDX_W-1:0];
                wr_data.key  = rd_data.key;
                wr_data.hits = hits_inc;
            end
            WR_SHIFT:
            begin
                wr_addr = pos_reg;
                wr_data = rd_data;
            end
            default:
            begin
                wr_addr = pos_reg;
                wr_data = hold_reg;
            end
        endcase
    end

    // Result register
    always_comb
    begin
        res_next             = res_reg;
        res_next.last        = 1'b1;
        res_next.entry_count = cnt_out(used_reg);
        res_next.entry_key   = key_reg;
        res_next.entry_hits  = '0;
        case (cmd.out_sel)
            RES_REJECT:
            begin
                res_next.status = ST_REJECTED;
            end
            RES_HIT:
            begin
                res_next.status     = ST_HIT;
                res_next.entry_hits = hits_out(hits_inc);
            end
            RES_APPEND:
            begin
                res_next.status      = ST_APPENDED;
                res_next.entry_hits  = hits_out(HIT_WIDTH'(1));
                res_next.entry_count = cnt_out(used_reg + 1'b1);
            end
            RES_FULL:
            begin
                res_next.status = ST_FULL;
            end
            RES_DUMP:
            begin
                res_next.status     = ST_DUMP;
                res_next.entry_key  = rd_data.key;
                res_next.entry_hits = hits_out(rd_data.hits);
                res_next.last       = idx_last;
            end
            default:
            begin
                res_next.status      = ST_EMPTY;
                res_next.entry_key   = '0;
                res_next.entry_count = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Status back to the controller
    always_comb
    begin
        st.op          = op_reg;
        st.key_ones    = (key_reg == NO_KEY);
        st.full        = (used_reg == CNT_W'(TABLE_DEPTH));
        st.used_zero   = (used_reg == '0);
        st.idx_at_used = (idx_reg == used_reg);
        st.idx_last    = idx_last;
        st.match       = (rd_data.key == key_reg);
        st.pos_zero    = (pos_reg == '0);
        st.hits_lt     = (rd_data.hits < hold_reg.hits);
        st.out_free    = !res_valid_reg || res_ready;
    end

endmodule
`default_nettype wire

// ===== sim/unique_key_hit_counter_test.sv =====
// Testbench for the unique key hit counter: directed and random requests, checked results.
`timescale 1ns / 100ps
`default_nettype none
module unique_key_hit_counter_test;
    import ukhc_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;

    // Opcode with no operation behind it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic res_valid;
    logic res_ready;
    res_t res;

    unique_key_hit_counter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    // Predicted table contents
    logic [KEY_W-1:0]     tbl_keys[TABLE_DEPTH];
    logic [HIT_WIDTH-1:0] tbl_hits[TABLE_DEPTH];
    int                   tbl_used;

    req_t pending_reqs[$];
    res_t expected_results[$];
    int   error_count;
    int   cycle_count;
    int   reqs_sent;
    int   results_seen;
    int   dump_entries_seen;
    int   req_gap;
    int   res_gap;

    always #5 clk = ~clk;

    task automatic report(input string what, input res_t got, input res_t want);
        error_count++;
        $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    endtask

    function automatic res_t make_res(input logic [2:0] st, input logic [KEY_W-1:0] k,
                                      input logic [HIT_WIDTH-1:0] h, input int cnt,
                                      input logic lst);
        res_t r;
        r.status      = st;
        r.entry_key   = k;
        r.entry_hits  = h;
        r.entry_count = cnt[OUT_CNT_W-1:0];
        r.last        = lst;
        return r;
    endfunction

    // Compute the results of one accepted request and advance the table
    task automatic predict_table_step(input req_t r);
        int                   i;
        int                   j;
        logic [KEY_W-1:0]     k;
        logic [HIT_WIDTH-1:0] h;
        if (r.op == OP_ADD)
        begin
            if (r.key == NO_KEY)
            begin
                expected_results.push_back(make_res(ST_REJECTED, r.key, '0, tbl_used, 1'b1));
                return;
            end
            for (i = 0; i < tbl_used; i++)
            begin
                if (tbl_keys[i] == r.key)
                begin
                    if (tbl_hits[i] != HIT_MAX)
                        tbl_hits[i]++;
                    expected_results.push_back(make_res(ST_HIT, r.key, tbl_hits[i],
                                                        tbl_used, 1'b1));
                    return;
                end
            end
            if (tbl_used >= TABLE_DEPTH)
            begin
                expected_results.push_back(make_res(ST_FULL, r.key, '0, tbl_used, 1'b1));
                return;
            end
            tbl_keys[tbl_used] = r.key;
            tbl_hits[tbl_used] = 1;
            tbl_used++;
            expected_results.push_back(make_res(ST_APPENDED, r.key, 1, tbl_used, 1'b1));
        end
        else if (r.op == OP_DUMP)
        begin
            if (tbl_used == 0)
            begin
                expected_results.push_back(make_res(ST_EMPTY, '0, '0, 0, 1'b1));
                return;
            end
            // stable insertion sort, descending by hits
            for (i = 1; i < tbl_used; i++)
            begin
                k = tbl_keys[i];
                h = tbl_hits[i];
                j = i;
                while (j > 0 && tbl_hits[j-1] < h)
                begin
                    tbl_keys[j] = tbl_keys[j-1];
                    tbl_hits[j] = tbl_hits[j-1];
                    j--;
                end
                tbl_keys[j] = k;
                tbl_hits[j] = h;
            end
            for (i = 0; i < tbl_used; i++)
                expected_results.push_back(make_res(ST_DUMP, tbl_keys[i], tbl_hits[i],
                                                    tbl_used, i == tbl_used - 1));
        end
        else if (r.op == OP_CLEAR)
        begin
            tbl_used = 0;
            expected_results.push_back(make_res(ST_EMPTY, '0, '0, 0, 1'b1));
        end
        else
        begin
            expected_results.push_back(make_res(ST_REJECTED, r.key, '0, tbl_used, 1'b1));
        end
    endtask

    function automatic req_t make_req(input logic [1:0] o, input logic [KEY_W-1:0] k);
        req_t r;
        r.op  = o;
        r.key = k;
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // Driver: hold each request until accepted, idle a random gap between
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            req_gap   <= 0;
        end
        else if (req_valid && !req_ready)
        begin
            // hold
        end
        else if (req_valid && req_ready && req_gap == 0 && pending_reqs.size() > 0 &&
                 $urandom_range(0, 3) == 0)
        begin
            // back to back: keep valid high, swap payload
            predict_table_step(req);
            reqs_sent <= reqs_sent + 1;
            req       <= pending_reqs.pop_front();
            req_gap   <= $urandom_range(0, 18) * ($urandom_range(0, 2) == 0);
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                predict_table_step(req);
                reqs_sent <= reqs_sent + 1;
            end
            if (req_gap > 0)
            begin
                req_valid <= 1'b0;
                req_gap   <= req_gap - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                req_valid <= 1'b1;
                req       <= pending_reqs.pop_front();
                req_gap   <= $urandom_range(0, 18) * ($urandom_range(0, 2) == 0);
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Monitor: check accepted results, stall the receiver at random
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            res_gap   <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                results_seen++;
                if (res.status == ST_DUMP)
                    dump_entries_seen++;
                if (expected_results.size() == 0)
                    report("unexpected result", res, '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (res.status !== want.status)
                        report("status", res, want);
                    if (res.entry_key !== want.entry_key)
                        report("entry_key", res, want);
                    if (res.entry_hits !== want.entry_hits)
                        report("entry_hits", res, want);
                    if (res.entry_count !== want.entry_count)
                        report("entry_count", res, want);
                    if (res.last !== want.last)
                        report("last", res, want);
                end
            end
            if (res_gap > 0)
            begin
                res_ready <= 1'b0;
                res_gap   <= res_gap - 1;
            end
            else
            begin
                res_ready <= 1'b1;
                if (res_valid && res_ready)
                    res_gap <= $urandom_range(0, 18) * ($urandom_range(0, 2) == 0);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Fill the request queue: directed part, then random sequences
    initial
    begin
        logic [KEY_W-1:0] pool[8];
        int               n;
        int               i;
        int               mode;
        clk            = 1'b0;
        rst_n          = 1'b0;
        error_count    = 0;
        cycle_count    = 0;
        reqs_sent      = 0;
        results_seen   = 0;
        dump_entries_seen = 0;
        tbl_used       = 0;
        req_valid      = 1'b0;
        req            = '0;
        res_ready      = 1'b0;

        // empty dump, rejected key, unused op, key extremes, hits, ties, clear
        pending_reqs.push_back(make_req(OP_DUMP, '0));
        pending_reqs.push_back(make_req(OP_ADD, NO_KEY));
        pending_reqs.push_back(make_req(OP_UNUSED, 64'h5555_aaaa_0f0f_f0f0));
        pending_reqs.push_back(make_req(OP_ADD, '0));
        pending_reqs.push_back(make_req(OP_ADD, 64'hffff_ffff_ffff_fffe));
        pending_reqs.push_back(make_req(OP_ADD, 64'h8000_0000_0000_0000));
        pending_reqs.push_back(make_req(OP_ADD, 64'hffff_ffff_ffff_fffe));
        pending_reqs.push_back(make_req(OP_ADD, 64'h8000_0000_0000_0000));
        pending_reqs.push_back(make_req(OP_ADD, 64'h8000_0000_0000_0000));
        pending_reqs.push_back(make_req(OP_ADD, 64'h7fff_ffff_ffff_ffff));
        pending_reqs.push_back(make_req(OP_DUMP, '0));
        pending_reqs.push_back(make_req(OP_DUMP, '0));
        pending_reqs.push_back(make_req(OP_CLEAR, '0));
        pending_reqs.push_back(make_req(OP_DUMP, '0));
        pending_reqs.push_back(make_req(OP_CLEAR, '0));
        pending_reqs.push_back(make_req(OP_UNUSED, NO_KEY));

        // fill the table, then an unseen key is dropped, the all-ones key rejected and the full table dumped
        for (i = 0; i < TABLE_DEPTH; i++)
            pending_reqs.push_back(make_req(OP_ADD, rand_key() & ~64'h1));
        pending_reqs.push_back(make_req(OP_ADD, 64'h0000_0000_0000_0001));
        pending_reqs.push_back(make_req(OP_ADD, NO_KEY));
        pending_reqs.push_back(make_req(OP_DUMP, '0));
        pending_reqs.push_back(make_req(OP_CLEAR, '0));

        // random part: runs drawn from a small key pool so hits and ties build up
        n = 0;
        while (n < 400)
        begin
            for (i = 0; i < 8; i++)
                pool[i] = rand_key();
            mode = $urandom_range(0, 9);
            repeat ($urandom_range(3, 24))
            begin
                if (mode == 0)
                    pending_reqs.push_back(make_req(2'($urandom_range(0, 3)), rand_key()));
                else if ($urandom_range(0, 15) == 0)
                    pending_reqs.push_back(make_req(OP_ADD, rand_key()));
                else if ($urandom_range(0, 30) == 0)
                    pending_reqs.push_back(make_req(OP_ADD, NO_KEY));
                else
                    pending_reqs.push_back(make_req(OP_ADD,
                                                    pool[3'($urandom_range(0, 7))]));
                n++;
            end
            pending_reqs.push_back(make_req(OP_DUMP, '0));
            n++;
            if ($urandom_range(0, 2) == 0)
            begin
                pending_reqs.push_back(make_req(OP_CLEAR, '0));
                n++;
            end
        end
        pending_reqs.push_back(make_req(OP_DUMP, '0));

        repeat (5) @(posedge clk);
        rst_n = 1'b1;

        // wait for all requests to be taken, then for the results to drain
        wait (pending_reqs.size() == 0);
        @(posedge clk iff (req_valid && req_ready));
        @(posedge clk);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge clk);

        $display("Sent %0d requests, checked %0d results (%0d dump entries).",
                 reqs_sent, results_seen, dump_entries_seen);
        if (error_count == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
